// File: hw/rtl/sdx_pkg.sv
`timescale 1ns / 1ps

package sdx_pkg;

  // Bytes beyond this count within one name are ignored.
  localparam int unsigned MaxChars = 20;
  localparam int unsigned PosW     = 5;
  localparam int unsigned NumDigits = 3;

  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChZ     = 8'h5A;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] CaseGap = 8'h20;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       is_last;
  } sdx_in_t;

  typedef struct packed {
    logic [7:0] code_letter;
    logic [2:0] digit_one;
    logic [2:0] digit_two;
    logic [2:0] digit_three;
  } sdx_out_t;

  typedef struct packed {
    logic [PosW-1:0]           position;
    logic [7:0]                lead_char;
    logic [7:0]                prior_letter;
    logic [1:0]                digit_count;
    logic [NumDigits-1:0][2:0] digits;
    logic                      name_ended;
  } sdx_state_t;

  localparam sdx_state_t StateReset = '{
    position:     '0,
    lead_char:    '0,
    prior_letter: ChSpace,
    digit_count:  '0,
    digits:       '0,
    name_ended:   1'b0
  };

  // Soundex digit for letter index 0 (A) .. 25 (Z).
  function automatic logic [2:0] letter_digit(input logic [4:0] idx);
    logic [2:0] d;
    case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                             d = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25:  d = 3'd2;
      5'd3, 5'd19:                                          d = 3'd3;
      5'd11:                                                d = 3'd4;
      5'd12, 5'd13:                                         d = 3'd5;
      5'd17:                                                d = 3'd6;
      default:                                              d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/soundex_encoder_top.sv
`timescale 1ns / 1ps

// Streaming Soundex coder. Feed the bytes of a name one beat per cycle on
// the input channel, with is_last set on the final byte; one result beat
// (code letter plus three digits, missing digits as 0) appears in the cycle
// after that final byte is taken. Lowercase letters are folded to upper
// case, K as the lead letter becomes C, and a leading PH becomes F. Bytes
// past the twentieth, and everything after a zero byte that is not the
// first, are ignored until is_last. The block takes one byte every cycle:
// all per-byte work (case fold, table lookup, compare with the previous
// letter) sits in one combinational step between the name state register
// and the result register. Input ready drops only when a final byte
// arrives while the previous result is still held and not taken.

module soundex_encoder_top import sdx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sdx_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sdx_out_t out_data_o
);

  sdx_state_t state_q, state_d, step_state;
  logic       out_valid_q, out_valid_d;
  sdx_out_t   out_data_q, out_data_d;
  logic       in_fire;
  logic       out_free;

  sdx_next u_next (
    .state_i (state_q),
    .byte_i  (in_data_i.name_byte),
    .state_o (step_state)
  );

  // Result slot is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  // Non-final beats never produce a result, so take them regardless.
  assign in_ready_o = out_free || !in_data_i.is_last;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (in_fire) begin
      if (in_data_i.is_last) begin
        // Emit the finished code and clear for the next name.
        out_valid_d            = 1'b1;
        out_data_d.code_letter = step_state.lead_char;
        out_data_d.digit_one   = step_state.digits[0];
        out_data_d.digit_two   = step_state.digits[1];
        out_data_d.digit_three = step_state.digits[2];
        state_d                = StateReset;
      end else begin
        state_d = step_state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload; no reset needed.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hw/rtl/sdx_next.sv
`timescale 1ns / 1ps

module sdx_next import sdx_pkg::*; (
  input  sdx_state_t state_i,
  input  logic [7:0] byte_i,
  output sdx_state_t state_o
);

  logic [7:0] up;
  logic       is_letter;
  logic [7:0] letter_idx;
  logic [2:0] digit;

  always_comb begin
    up = ((byte_i >= ChLowA) && (byte_i <= ChLowZ)) ? byte_i - CaseGap : byte_i;
    is_letter  = (up >= ChA) && (up <= ChZ);
    letter_idx = up - ChA;
    digit      = letter_digit(letter_idx[4:0]);

    state_o = state_i;
    if (!state_i.name_ended) begin
      if (state_i.position >= PosW'(MaxChars)) begin
        state_o.name_ended = 1'b1;
      end else if (state_i.position == '0) begin
        // Lead byte: K folds to C.
        state_o.lead_char = (up == ChK) ? ChC : up;
        state_o.position  = PosW'(1);
      end else if (up == 8'h00) begin
        state_o.name_ended = 1'b1;
      end else begin
        // PH at the start folds to F.
        if ((state_i.position == PosW'(1)) && (state_i.lead_char == ChP) && (up == ChH)) begin
          state_o.lead_char = ChF;
        end
        if ((state_i.digit_count < 2'(NumDigits)) && is_letter &&
            (up != state_i.prior_letter)) begin
          state_o.prior_letter = up;
          if (digit != 3'd0) begin
            state_o.digits[state_i.digit_count] = digit;
            state_o.digit_count = state_i.digit_count + 2'd1;
          end
        end
        state_o.position = state_i.position + PosW'(1);
      end
    end
  end

endmodule

// File: bench/soundex_checker.sv
`timescale 1ns / 1ps

module soundex_checker import sdx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  sdx_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  sdx_out_t    out_data_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned codes_waiting_o,
  output int unsigned bytes_seen_o,
  output int unsigned names_coded_o,
  output int unsigned limit_hits_o,
  output int unsigned zero_stops_o,
  output int unsigned full_codes_o
);

  localparam logic [7:0] NulByte = 8'h00;

  // Digit per letter, A first: 01230120022455012623010202
  localparam logic [0:25][2:0] SdxDigits = {
    3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
    3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
  };

  // Predicted name state
  logic [PosW-1:0] name_pos;
  logic [7:0]      lead_letter;
  logic [7:0]      prev_letter;
  logic [1:0]      digit_cnt;
  logic [2:0]      digit_held [NumDigits];
  logic            name_done;

  sdx_out_t expected_codes [$];
  sdx_out_t oldest_code;

  function automatic void clear_name();
    name_pos    = '0;
    lead_letter = '0;
    prev_letter = ChSpace;
    digit_cnt   = '0;
    for (int i = 0; i < NumDigits; i++) digit_held[i] = '0;
    name_done   = 1'b0;
  endfunction

  // Fold one accepted beat into the name state; queue a code on the final byte.
  function automatic void absorb_byte(input logic [7:0] raw, input logic last);
    logic [7:0] b;
    logic [4:0] idx;
    logic [2:0] d;
    b = (raw >= ChLowA && raw <= ChLowZ) ? raw - CaseGap : raw;
    if (!name_done) begin
      if (name_pos >= MaxChars) begin
        name_done = 1'b1;
        limit_hits_o++;
      end else if (name_pos == '0) begin
        lead_letter = (b == ChK) ? ChC : b;
        name_pos    = PosW'(1);
      end else if (b == NulByte) begin
        name_done = 1'b1;
        zero_stops_o++;
      end else begin
        if (name_pos == 1 && lead_letter == ChP && b == ChH) lead_letter = ChF;
        if (digit_cnt < NumDigits && b >= ChA && b <= ChZ && b != prev_letter) begin
          prev_letter = b;
          idx = 5'(b - ChA);
          d   = SdxDigits[idx];
          if (d != 3'd0) begin
            digit_held[digit_cnt] = d;
            digit_cnt++;
            if (digit_cnt == NumDigits) full_codes_o++;
          end
        end
        name_pos++;
      end
    end
    bytes_seen_o++;
    if (last) begin
      expected_codes.push_back('{lead_letter, digit_held[0], digit_held[1], digit_held[2]});
      names_coded_o++;
      clear_name();
    end
  endfunction

  function automatic void flag_field(input string field, input logic [7:0] want,
                                     input logic [7:0] got);
    if (want !== got) begin
      mismatch_cnt_o++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_name();
      expected_codes.delete();
      mismatch_cnt_o  = 0;
      codes_waiting_o = 0;
      bytes_seen_o    = 0;
      names_coded_o   = 0;
      limit_hits_o    = 0;
      zero_stops_o    = 0;
      full_codes_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) absorb_byte(in_data_i.name_byte, in_data_i.is_last);
      if (out_valid_i && out_ready_i) begin
        if (expected_codes.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t: code beat mismatch, expected no beat, got %h", $time, out_data_i);
        end else begin
          oldest_code = expected_codes.pop_front();
          flag_field("code_letter", oldest_code.code_letter, out_data_i.code_letter);
          flag_field("digit_one", 8'(oldest_code.digit_one), 8'(out_data_i.digit_one));
          flag_field("digit_two", 8'(oldest_code.digit_two), 8'(out_data_i.digit_two));
          flag_field("digit_three", 8'(oldest_code.digit_three),
                     8'(out_data_i.digit_three));
        end
      end
      codes_waiting_o = expected_codes.size();
    end
  end

endmodule

// File: bench/tb_soundex_encoder_top.sv
`timescale 1ns / 1ps

module tb_soundex_encoder_top import sdx_pkg::*;;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  sdx_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  sdx_out_t out_data_o;

  int unsigned mismatch_cnt, codes_waiting, bytes_seen, names_coded;
  int unsigned limit_hits, zero_stops, full_codes;

  // Percent chance per cycle that the sender holds off / the sink stalls.
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;

  // Bytes of the name about to be sent; the last one carries is_last.
  logic [7:0] name_bytes [$];

  soundex_encoder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  soundex_checker u_soundex_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .mismatch_cnt_o  (mismatch_cnt),
    .codes_waiting_o (codes_waiting),
    .bytes_seen_o    (bytes_seen),
    .names_coded_o   (names_coded),
    .limit_hits_o    (limit_hits),
    .zero_stops_o    (zero_stops),
    .full_codes_o    (full_codes)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Drop out_ready at random on the falling edge; a zero stall rate keeps it high.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Append the characters of a string to the pending name.
  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) name_bytes.push_back(s[i]);
  endtask

  // Send the pending name one beat at a time. Each beat may be preceded by
  // idle cycles; once valid is up it holds, payload unchanged, until taken.
  // Valid is left high after the final beat so back-to-back names flow.
  task automatic send_name();
    for (int i = 0; i < name_bytes.size(); i++) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
      in_valid_i          = 1'b1;
      in_data_i.name_byte = name_bytes[i];
      in_data_i.is_last   = (i == name_bytes.size() - 1);
      do @(posedge clk_i); while (!in_ready_o);
      @(negedge clk_i);
    end
    name_bytes.delete();
  endtask

  initial begin
    int unsigned phase_bytes;
    int unsigned name_len;
    int unsigned pick;
    logic [7:0]  b;
    logic        ph_lead;

    // Hold reset low, then release it on a falling edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed names, free-flowing channels.
    // One-byte name, lowercase k as lead: gives C with no digits.
    load_text("k");
    send_name();
    // Zero as the first byte is kept as the letter; the rest is still scanned.
    name_bytes.push_back(8'h00);
    load_text("bc");
    send_name();
    // Zero byte after the lead ends the name; the trailing D is ignored.
    load_text("B");
    name_bytes.push_back(8'h00);
    load_text("D");
    send_name();
    // Leading ph folds to F; 0xFF and '-' are skipped, e and a carry no digit,
    // B repeats b and is skipped, d lands at the final counted position and
    // the bytes past the length limit are ignored.
    load_text("ph");
    name_bytes.push_back(8'hFF);
    load_text("e-bBa###########dcL");
    send_name();
    // Three digits fill the code; the trailing m is ignored.
    load_text("tcdlm");
    send_name();

    // Random names over four flow-control phases: free flow, sparse input,
    // stalled output, then both at a light rate.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 80; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 80; end
        default: begin sender_idle_pct = 19; sink_stall_pct = 19; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 330) begin
        // Mostly short names; a few run past the length limit.
        pick = $urandom_range(99);
        if (pick < 85)      name_len = $urandom_range(8, 1);
        else if (pick < 97) name_len = $urandom_range(19, 9);
        else                name_len = $urandom_range(26, 20);
        ph_lead = 1'b0;
        for (int k = 0; k < name_len; k++) begin
          pick = $urandom_range(99);
          if (k == 0 && pick < 10) begin
            b = $urandom_range(1) ? ChK : ChK + CaseGap;
          end else if (k == 0 && pick < 20) begin
            b       = $urandom_range(1) ? ChP : ChP + CaseGap;
            ph_lead = 1'b1;
          end else if (k == 1 && ph_lead && pick < 80) begin
            b = $urandom_range(1) ? ChH : ChH + CaseGap;
          end else if (pick < 70 || k == 0 && pick >= 90) begin
            b = ($urandom_range(1) ? ChA : ChLowA) + 8'($urandom_range(25));
          end else if (pick < 85) begin
            b = 8'($urandom_range(255, 1));
          end else if (pick < 90) begin
            b = 8'h00;
          end else begin
            // Repeat the previous byte, possibly with the case flipped.
            b = name_bytes[$];
            if ($urandom_range(1) && b >= ChA && b <= ChZ) b = b + CaseGap;
          end
          name_bytes.push_back(b);
        end
        phase_bytes += name_len;
        send_name();
      end
    end

    in_valid_i = 1'b0;

    // Drain: wait for every predicted code, then a few quiet cycles.
    while (codes_waiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Coded %0d names from %0d bytes under four flow-control phases.",
             names_coded, bytes_seen);
    $display("Length cutoffs %0d, zero-byte stops %0d, three-digit codes %0d.",
             limit_hits, zero_stops, full_codes);
    if (mismatch_cnt == 0 && codes_waiting == 0) begin
      $display("soundex_encoder_top verification clean");
    end else begin
      $display("soundex_encoder_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Timed out with %0d codes outstanding.", codes_waiting);
    $display("soundex_encoder_top verification failed");
    $finish;
  end

endmodule
